// File: hdl/bch_pkg.sv
// Shared types, codes and GF(64) helpers for the BCH (63,51) decoder.
`timescale 1ns / 1ps

package bch_pkg;

    // Code and field geometry
    localparam int CODE_LEN = 63;
    localparam int GF_M = 6;
    localparam logic [GF_M:0] FIELD_POLY = 7'h43;

    // Depth of the queue between the syndrome front and the correction back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    // Result status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_ONE = 2'd1;
    localparam logic [1:0] ST_TWO = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // Word classes found from the syndromes
    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_FAIL = 2'd1;
    localparam logic [1:0] CLS_ONE = 2'd2;
    localparam logic [1:0] CLS_TWO = 2'd3;

    typedef logic [GF_M-1:0] t_gf;
    typedef logic [CODE_LEN-1:0] t_word;
    typedef t_gf t_gf_tab [CODE_LEN];

    // Item passed from the front to the back
    typedef struct packed {
        t_word word;
        t_gf   s1;
        t_gf   s3;
    } t_synd_item;

    // Multiply two field elements modulo x^6 + x + 1
    function automatic t_gf gf_mul(input t_gf a, input t_gf b);
        t_gf acc;
        logic [GF_M:0] x;
        acc = '0;
        x = {1'b0, a};
        for (int k = 0; k < GF_M; k++) begin
            if (b[k]) begin
                acc = acc ^ x[GF_M-1:0];
            end
            x = {x[GF_M-1:0], 1'b0};
            if (x[GF_M]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // Build the table of successive powers of a step element
    function automatic t_gf_tab gen_pow_tab(input t_gf step);
        t_gf_tab tab;
        t_gf p;
        p = t_gf'(1);
        for (int j = 0; j < CODE_LEN; j++) begin
            tab[j] = p;
            p = gf_mul(p, step);
        end
        return tab;
    endfunction

    // alpha^j, alpha^(2j) and alpha^(3j)
    localparam t_gf_tab POW1_TAB = gen_pow_tab(t_gf'(2));
    localparam t_gf_tab POW2_TAB = gen_pow_tab(t_gf'(4));
    localparam t_gf_tab POW3_TAB = gen_pow_tab(t_gf'(8));

    // Square a field element; squaring is linear, so this is an XOR network
    function automatic t_gf gf_sq(input t_gf a);
        t_gf acc;
        acc = '0;
        for (int i = 0; i < GF_M; i++) begin
            if (a[i]) begin
                acc = acc ^ POW1_TAB[2*i];
            end
        end
        return acc;
    endfunction

endpackage

// File: hdl/bch_front.sv
// Front end: accepts received words and forms the syndromes S1 and S3.
`timescale 1ns / 1ps

module bch_front (
    input  logic                 i_push,
    input  bch_pkg::t_word       i_received_word,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_wr,
    output bch_pkg::t_synd_item  o_item
);

    bch_pkg::t_gf s1;
    bch_pkg::t_gf s3;

    // Evaluate the word at alpha and alpha^3
    always_comb begin
        s1 = '0;
        s3 = '0;
        for (int j = 0; j < bch_pkg::CODE_LEN; j++) begin
            if (i_received_word[j]) begin
                s1 = s1 ^ bch_pkg::POW1_TAB[j];
                s3 = s3 ^ bch_pkg::POW3_TAB[j];
            end
        end
    end

    // Transfer into the queue whenever it has room
    assign o_full = i_q_full;
    assign o_wr = i_push && !i_q_full;
    assign o_item = '{word: i_received_word, s1: s1, s3: s3};

endmodule

// File: hdl/bch_queue.sv
// Short queue of syndrome items between the front and back parts.
`timescale 1ns / 1ps

module bch_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  bch_pkg::t_synd_item  i_item,
    input  logic                 i_rd,
    output logic                 o_full,
    output logic                 o_empty,
    output bch_pkg::t_synd_item  o_item
);

    bch_pkg::t_synd_item r_mem [bch_pkg::Q_DEPTH];
    logic [bch_pkg::Q_AW-1:0] r_wptr, n_wptr;
    logic [bch_pkg::Q_AW-1:0] r_rptr, n_rptr;
    logic [bch_pkg::Q_AW:0]   r_cnt, n_cnt;
    logic                     wr_en;
    logic                     rd_en;

    assign o_full = (r_cnt == (bch_pkg::Q_AW+1)'(bch_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item = r_mem[r_rptr];
    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    // Advance pointers and count
    always_comb begin
        n_wptr = wr_en ? r_wptr + 1'b1 : r_wptr;
        n_rptr = rd_en ? r_rptr + 1'b1 : r_rptr;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// File: hdl/bch_back.sv
// Back end: classifies syndromes, runs the Chien search and queues results.
`timescale 1ns / 1ps

module bch_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  bch_pkg::t_synd_item  i_item,
    output logic                 o_q_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output bch_pkg::t_word       o_corrected_word,
    output logic [1:0]           o_decode_status
);

    // Classification stage
    logic                r_st_vld, n_st_vld;
    bch_pkg::t_word      r_st_word;
    bch_pkg::t_gf        r_st_s1;
    bch_pkg::t_gf        r_st_s1sq;
    bch_pkg::t_gf        r_st_aux;
    logic [1:0]          r_st_cls;

    // Result queue
    bch_pkg::t_word      r_oq_word [2];
    logic [1:0]          r_oq_stat [2];
    logic                r_oq_wptr, n_oq_wptr;
    logic                r_oq_rptr, n_oq_rptr;
    logic [1:0]          r_oq_cnt, n_oq_cnt;

    bch_pkg::t_gf        s1sq;
    bch_pkg::t_gf        cube;
    logic [1:0]          cls;
    logic                ld;
    logic                adv;
    logic                oq_pop;
    logic [bch_pkg::CODE_LEN-1:0] root;
    logic [bch_pkg::CODE_LEN-1:0] hit;
    logic [bch_pkg::CODE_LEN-1:0] mask;
    logic [1:0]          stat;

    // Handshake between stages
    assign oq_pop = i_pop && (r_oq_cnt != 2'd0);
    assign adv = r_st_vld && ((r_oq_cnt != 2'd2) || oq_pop);
    assign ld = !i_q_empty && (!r_st_vld || adv);
    assign o_q_rd = ld;
    assign n_st_vld = ld || (r_st_vld && !adv);

    // Classify the word from S1 and S3
    always_comb begin
        s1sq = bch_pkg::gf_sq(i_item.s1);
        cube = bch_pkg::gf_mul(s1sq, i_item.s1);
        if (i_item.s1 == '0) begin
            cls = (i_item.s3 == '0) ? bch_pkg::CLS_ZERO : bch_pkg::CLS_FAIL;
        end else if (cube == i_item.s3) begin
            cls = bch_pkg::CLS_ONE;
        end else begin
            cls = bch_pkg::CLS_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= 1'b0;
        end else begin
            r_st_vld <= n_st_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_st_word <= i_item.word;
            r_st_s1 <= i_item.s1;
            r_st_s1sq <= s1sq;
            r_st_aux <= cube ^ i_item.s3;
            r_st_cls <= cls;
        end
    end

    // Chien search lanes: locator S1*x^2 + S1^2*x + aux at x = alpha^j
    always_comb begin
        for (int j = 0; j < bch_pkg::CODE_LEN; j++) begin
            root[j] = ((bch_pkg::gf_mul(r_st_s1, bch_pkg::POW2_TAB[j])
                       ^ bch_pkg::gf_mul(r_st_s1sq, bch_pkg::POW1_TAB[j])
                       ^ r_st_aux) == '0);
            hit[j] = (r_st_s1 == bch_pkg::POW1_TAB[j]);
        end
    end

    // Pick the error mask and status; in the two-error class the locator gives two roots or none
    always_comb begin
        case (r_st_cls)
            bch_pkg::CLS_ZERO: begin
                mask = '0;
                stat = bch_pkg::ST_NONE;
            end
            bch_pkg::CLS_ONE: begin
                mask = hit;
                stat = bch_pkg::ST_ONE;
            end
            bch_pkg::CLS_TWO: begin
                if (|root) begin
                    mask = root;
                    stat = bch_pkg::ST_TWO;
                end else begin
                    mask = '0;
                    stat = bch_pkg::ST_FAIL;
                end
            end
            default: begin
                mask = '0;
                stat = bch_pkg::ST_FAIL;
            end
        endcase
    end

    // Result queue control
    always_comb begin
        n_oq_wptr = adv ? ~r_oq_wptr : r_oq_wptr;
        n_oq_rptr = oq_pop ? ~r_oq_rptr : r_oq_rptr;
        n_oq_cnt = r_oq_cnt;
        if (adv && !oq_pop) begin
            n_oq_cnt = r_oq_cnt + 1'b1;
        end else if (oq_pop && !adv) begin
            n_oq_cnt = r_oq_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wptr <= 1'b0;
            r_oq_rptr <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            r_oq_wptr <= n_oq_wptr;
            r_oq_rptr <= n_oq_rptr;
            r_oq_cnt <= n_oq_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oq_word[r_oq_wptr] <= r_st_word ^ mask;
            r_oq_stat[r_oq_wptr] <= stat;
        end
    end

    assign o_empty = (r_oq_cnt == 2'd0);
    assign o_corrected_word = r_oq_word[r_oq_rptr];
    assign o_decode_status = r_oq_stat[r_oq_rptr];

endmodule

// File: hdl/bch_63_51_double_error_decoder_unit.sv
// Top level of the BCH (63,51) double-error decoder.
// A transferred word passes through the syndrome queue, then the classification stage,
// then the result queue, before it shows on the result ports.
// Throughput: one word per cycle while results are popped, set by the unrolled syndrome and 63-lane Chien logic.
// Reset: synchronous, active low; it empties both queues and the classification stage.
`timescale 1ns / 1ps

module bch_63_51_double_error_decoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  bch_pkg::t_word       i_received_word,
    output logic                 o_empty,
    input  logic                 i_pop,
    output bch_pkg::t_word       o_corrected_word,
    output logic [1:0]           o_decode_status
);

    logic                q_wr;
    logic                q_rd;
    logic                q_full;
    logic                q_empty;
    bch_pkg::t_synd_item q_in;
    bch_pkg::t_synd_item q_out;

    // Syndrome front
    bch_front u_front (
        .i_push          (i_push),
        .i_received_word (i_received_word),
        .i_q_full        (q_full),
        .o_full          (o_full),
        .o_wr            (q_wr),
        .o_item          (q_in)
    );

    // Decoupling queue
    bch_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_in),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    // Correction back
    bch_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_item           (q_out),
        .o_q_rd           (q_rd),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_corrected_word (o_corrected_word),
        .o_decode_status  (o_decode_status)
    );

endmodule

// File: hdl/bch_chk.sv
// Port-level checker for the BCH decoder, bound to the top level.
`timescale 1ns / 1ps

module bch_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_push,
    input logic           o_full,
    input bch_pkg::t_word i_received_word,
    input logic           o_empty,
    input logic           i_pop,
    input bch_pkg::t_word o_corrected_word,
    input logic [1:0]     o_decode_status
);

    // Reset leaves no result waiting
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    // Reset leaves room for input
    a_rst_room: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input full after reset");

    // Back pressure only builds up behind waiting results
    a_full_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !o_empty)
        else $error("input full while no result waits");

    // Hold a waiting result until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
            (!o_empty && $stable(o_corrected_word) && $stable(o_decode_status)))
        else $error("waiting result changed before transfer");

    // A transferred word carries known bits
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |-> !$isunknown(i_received_word))
        else $error("unknown bits in transferred word");

endmodule

bind bch_63_51_double_error_decoder_unit bch_chk u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_push           (i_push),
    .o_full           (o_full),
    .i_received_word  (i_received_word),
    .o_empty          (o_empty),
    .i_pop            (i_pop),
    .o_corrected_word (o_corrected_word),
    .o_decode_status  (o_decode_status)
);
